FILE: src/teau_pkg.sv
// Shared types, constants and the elaboration-time builders of the two power-of-two tables.
// Used by teau_fmul and table_exp_approximation_unit; depends on nothing else.
package teau_pkg;

  localparam int unsigned FMUL_LAT = 6;
  localparam int unsigned PIPE_DEPTH = 1 + FMUL_LAT + 2 + FMUL_LAT;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] ZERO_BITS = 64'h0000_0000_0000_0000;
  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  localparam logic [3:0] ADDR_SCALE = 4'd0;
  localparam logic [3:0] ADDR_LIMIT = 4'd8;

  typedef enum logic [1:0] {
    CLS_ONE,
    CLS_TABLE,
    CLS_ZERO,
    CLS_NAN
  } cls_e;

  // ln 2 with 128 fraction bits.
  localparam logic [159:0] LN2_FX =
    {32'h0, 32'hB172_17F7, 32'hD1CF_79AB, 32'hC9E3_B398, 32'h03F2_F6AF};

  // Floor division of a 160-bit word by a small count, done bit by bit.
  function automatic logic [159:0] fx_div_small(input logic [159:0] w, input logic [5:0] n);
    logic [159:0] q;
    logic [6:0]   rem;
    q   = '0;
    rem = '0;
    for (int b = 159; b >= 0; b--) begin
      rem = {rem[5:0], w[b]};
      if (rem >= {1'b0, n}) begin
        rem  = rem - {1'b0, n};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Correctly rounded double pattern of 2^(i / 2^s), by the exponential series.
  function automatic logic [63:0] pow2_frac(input logic [7:0] i, input logic [4:0] s);
    logic [159:0] t;
    logic [159:0] y;
    logic [159:0] sum;
    logic [159:0] term;
    logic [319:0] prod;
    logic [51:0]  mant;
    logic         lower;
    t    = LN2_FX * {152'd0, i};
    y    = t >> s;
    sum  = {31'd0, 1'b1, 128'd0};
    term = sum;
    for (int n = 1; n <= 40; n++) begin
      prod = {160'd0, term} * {160'd0, y};
      term = fx_div_small(prod[287:128], 6'(n));
      sum  = sum + term;
    end
    mant  = sum[127:76];
    lower = |sum[74:0];
    return ONE_BITS + {12'd0, mant} + {63'd0, sum[75] & (lower | mant[0])};
  endfunction

  function automatic logic [16383:0] build_rom(input logic [4:0] s);
    logic [16383:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      r[k*64 +: 64] = pow2_frac(8'(k), s);
    end
    return r;
  endfunction

  localparam logic [16383:0] FINE_ROM   = build_rom(5'd16);
  localparam logic [16383:0] COARSE_ROM = build_rom(5'd8);

endpackage

FILE: src/table_exp_approximation_unit.sv
// Top level of the table-based exponential: configuration registers, pipeline control,
// truncation, table look-up and two teau_fmul instances. Depends on teau_pkg and teau_fmul.
//
//   Channel   Signals                                   Direction  Transfer
//   input     start_i, busy_o, x_bits_i                 in         start_i high, busy_o low
//   result    result_valid_o, result_bits_o             out        one cycle, strobed
//   config    psel, penable, pwrite, paddr, pwdata,     in/out     APB write access phase
//             prdata, pready
//
// An item's result passes through the input register, two six-stage double multipliers,
// the truncation and table stages between them and the output register before it is
// shown. A new item is taken in every cycle, so busy_o stays low.
// Reset clears the valid bits of the pipeline and both registers; data registers are not
// reset. The receiver cannot stall, so nothing in the pipeline ever waits.
module table_exp_approximation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] x_bits_i,
  output logic        result_valid_o,
  output logic [63:0] result_bits_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned Depth = teau_pkg::PIPE_DEPTH;

  // Configuration registers; user must write only while pipeline is empty, not enforced.
  logic [63:0] scale_q, limit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      limit_q <= '0;
    end else if (wr_en) begin
      if (paddr == teau_pkg::ADDR_SCALE) scale_q <= pwdata;
      if (paddr == teau_pkg::ADDR_LIMIT) limit_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == teau_pkg::ADDR_SCALE) prdata = scale_q;
    if (paddr == teau_pkg::ADDR_LIMIT) prdata = limit_q;
  end

  assign busy_o = 1'b0;

  // Classify the argument as it enters: the constant outcomes need no arithmetic.
  teau_pkg::cls_e cls_d;
  always_comb begin
    if (x_bits_i == '0) begin
      cls_d = teau_pkg::CLS_ONE;
    end else if (x_bits_i <= limit_q) begin
      cls_d = teau_pkg::CLS_TABLE;
    end else if (x_bits_i[63] && !((x_bits_i[62:52] == 11'h7FF) && (x_bits_i[51:0] != '0))) begin
      cls_d = teau_pkg::CLS_ZERO;
    end else begin
      cls_d = teau_pkg::CLS_NAN;
    end
  end

  // Valid bits and classes travel alongside the arithmetic.
  logic [Depth-1:0] vld_q;
  teau_pkg::cls_e   cls_q [Depth];
  logic [63:0]      x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q[0] <= cls_d;
    x_q      <= x_bits_i;
    for (int k = 1; k < Depth; k++) begin
      cls_q[k] <= cls_q[k-1];
    end
  end

  // First multiply: the argument times the configured scale.
  logic [63:0] prod1;
  teau_fmul u_fmul_scale (
    .clk_i(clk_i),
    .a_i  (x_q),
    .b_i  (scale_q),
    .p_o  (prod1)
  );

  // Truncate toward zero to int32 with saturation; a NaN product gives zero.
  logic [31:0] n_d;
  logic [52:0] int_mag;
  logic [5:0]  rsh;
  always_comb begin
    rsh     = 6'd52 - 6'(prod1[62:52] - 11'd1023);
    int_mag = {1'b1, prod1[51:0]} >> rsh;
    if ((prod1[62:52] == 11'h7FF) && (prod1[51:0] != '0)) begin
      n_d = 32'd0;
    end else if (prod1[62:52] >= 11'd1054) begin
      n_d = prod1[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (prod1[62:52] < 11'd1023) begin
      n_d = 32'd0;
    end else begin
      n_d = prod1[63] ? (32'd0 - int_mag[31:0]) : int_mag[31:0];
    end
  end

  logic [31:0] n_q;
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
  end

  // Table stage: fine power, and coarse power with the integer power of two folded in.
  logic [63:0] fine_q, w_q;
  always_ff @(posedge clk_i) begin
    fine_q <= teau_pkg::FINE_ROM[{n_q[7:0], 6'd0} +: 64];
    w_q    <= teau_pkg::COARSE_ROM[{n_q[15:8], 6'd0} +: 64] + {n_q[27:16], 52'd0};
  end

  // Second multiply: fine power times the adjusted coarse power.
  logic [63:0] prod2;
  teau_fmul u_fmul_power (
    .clk_i(clk_i),
    .a_i  (fine_q),
    .b_i  (w_q),
    .p_o  (prod2)
  );

  // Output register: the strobe lasts exactly one cycle per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cls_q[Depth-1])
      teau_pkg::CLS_ONE:   result_bits_o <= teau_pkg::ONE_BITS;
      teau_pkg::CLS_TABLE: result_bits_o <= prod2;
      teau_pkg::CLS_ZERO:  result_bits_o <= teau_pkg::ZERO_BITS;
      default:             result_bits_o <= teau_pkg::CANON_NAN;
    endcase
  end

endmodule

FILE: src/teau_fmul.sv
// Six-stage pipelined IEEE double multiplier, round to nearest even, canonical NaN out.
// Depends on teau_pkg for the NaN constant.
module teau_fmul (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  // Stage 1: unpack, specials and four partial products.
  logic        sa, sb, za, zb, ia, ib, na, nb;
  logic [52:0] ma, mb;
  logic [10:0] ea, eb;
  logic        spec_d;
  logic [63:0] specv_d;

  always_comb begin
    sa = a_i[63];
    sb = b_i[63];
    za = a_i[62:0] == '0;
    zb = b_i[62:0] == '0;
    ia = (a_i[62:52] == 11'h7FF) && (a_i[51:0] == '0);
    ib = (b_i[62:52] == 11'h7FF) && (b_i[51:0] == '0);
    na = (a_i[62:52] == 11'h7FF) && (a_i[51:0] != '0);
    nb = (b_i[62:52] == 11'h7FF) && (b_i[51:0] != '0);
    ma = {a_i[62:52] != '0, a_i[51:0]};
    mb = {b_i[62:52] != '0, b_i[51:0]};
    ea = (a_i[62:52] == '0) ? 11'd1 : a_i[62:52];
    eb = (b_i[62:52] == '0) ? 11'd1 : b_i[62:52];
    spec_d  = 1'b1;
    specv_d = teau_pkg::CANON_NAN;
    if (na || nb || (ia && zb) || (ib && za)) begin
      specv_d = teau_pkg::CANON_NAN;
    end else if (ia || ib) begin
      specv_d = {sa ^ sb, 11'h7FF, 52'd0};
    end else if (za || zb) begin
      specv_d = {sa ^ sb, 63'd0};
    end else begin
      spec_d = 1'b0;
    end
  end

  logic [51:0] hh_q;
  logic [52:0] hl_q, lh_q;
  logic [53:0] ll_q;
  logic [12:0] ee1_q;
  logic        sg1_q, sp1_q;
  logic [63:0] sv1_q;

  always_ff @(posedge clk_i) begin
    hh_q  <= {26'd0, ma[52:27]} * {26'd0, mb[52:27]};
    hl_q  <= {27'd0, ma[52:27]} * {26'd0, mb[26:0]};
    lh_q  <= {26'd0, ma[26:0]} * {27'd0, mb[52:27]};
    ll_q  <= {27'd0, ma[26:0]} * {27'd0, mb[26:0]};
    ee1_q <= {2'd0, ea} + {2'd0, eb};
    sg1_q <= sa ^ sb;
    sp1_q <= spec_d;
    sv1_q <= specv_d;
  end

  // Stage 2: full 106-bit product.
  logic [105:0] p2_q;
  logic [12:0]  ee2_q;
  logic         sg2_q, sp2_q;
  logic [63:0]  sv2_q;

  always_ff @(posedge clk_i) begin
    p2_q  <= ({hh_q, 54'd0}) + ({26'd0, hl_q, 27'd0} + {26'd0, lh_q, 27'd0})
             + {52'd0, ll_q};
    ee2_q <= ee1_q;
    sg2_q <= sg1_q;
    sp2_q <= sp1_q;
    sv2_q <= sv1_q;
  end

  // Stage 3: leading-zero count.
  logic [6:0] lz_d;
  always_comb begin
    lz_d = 7'd0;
    for (int k = 0; k < 106; k++) begin
      if (p2_q[k]) lz_d = 7'(105 - k);
    end
  end

  logic [105:0] p3_q;
  logic [6:0]   lz3_q;
  logic [12:0]  ee3_q;
  logic         sg3_q, sp3_q;
  logic [63:0]  sv3_q;

  always_ff @(posedge clk_i) begin
    p3_q  <= p2_q;
    lz3_q <= lz_d;
    ee3_q <= ee2_q;
    sg3_q <= sg2_q;
    sp3_q <= sp2_q;
    sv3_q <= sv2_q;
  end

  // Stage 4: normalise left, work out the biased exponent and any denormalising shift.
  logic signed [13:0] er_d;
  logic [7:0]         d_d;
  always_comb begin
    er_d = $signed({1'b0, ee3_q}) - 14'sd1022 - $signed({7'd0, lz3_q});
    if (er_d >= 14'sd1) begin
      d_d = 8'd0;
    end else if (er_d <= -14'sd107) begin
      d_d = 8'd108;
    end else begin
      d_d = 8'(14'sd1 - er_d);
    end
  end

  logic [105:0] p4_q;
  logic [7:0]   d4_q;
  logic [10:0]  ex4_q;
  logic         ov4_q, sg4_q, sp4_q;
  logic [63:0]  sv4_q;

  always_ff @(posedge clk_i) begin
    p4_q  <= p3_q << lz3_q;
    d4_q  <= d_d;
    ex4_q <= (er_d >= 14'sd1) ? er_d[10:0] : 11'd0;
    ov4_q <= er_d >= 14'sd2047;
    sg4_q <= sg3_q;
    sp4_q <= sp3_q;
    sv4_q <= sv3_q;
  end

  // Stage 5: denormalising right shift with sticky collection.
  logic [213:0] wide_d;
  assign wide_d = {p4_q, 108'd0} >> d4_q;

  logic [105:0] p5_q;
  logic         st5_q, ov5_q, sg5_q, sp5_q;
  logic [10:0]  ex5_q;
  logic [63:0]  sv5_q;

  always_ff @(posedge clk_i) begin
    p5_q  <= wide_d[213:108];
    st5_q <= |wide_d[107:0];
    ex5_q <= ex4_q;
    ov5_q <= ov4_q;
    sg5_q <= sg4_q;
    sp5_q <= sp4_q;
    sv5_q <= sv4_q;
  end

  // Stage 6: round to nearest even and pack.
  logic        inc_d;
  logic [62:0] mag_d;
  always_comb begin
    inc_d = p5_q[52] & ((|p5_q[51:0]) | st5_q | p5_q[53]);
    mag_d = {ex5_q, p5_q[104:53]} + {62'd0, inc_d};
  end

  always_ff @(posedge clk_i) begin
    if (sp5_q) begin
      p_o <= sv5_q;
    end else if (ov5_q) begin
      p_o <= {sg5_q, 11'h7FF, 52'd0};
    end else begin
      p_o <= {sg5_q, mag_d};
    end
  end

endmodule

FILE: sim/table_exp_approximation_unit_tb.sv
// Self-checking testbench for table_exp_approximation_unit: APB register set-up,
// bursty command stimulus and a scoreboard that predicts every result bit for bit.
// Depends on teau_pkg (for the canonical constants) and the RTL under src.
module table_exp_approximation_unit_tb;

  // ln 2 with 128 fraction bits, used to build the expected power-of-two tables.
  localparam logic [127:0] LN2_Q128 = 128'hB172_17F7_D1CF_79AB_C9E3_B398_03F2_F6AF;
  localparam int unsigned  CYCLE_LIMIT = 200000;
  localparam int unsigned  DRAIN_CYCLES = 40;

  // The scoreboard keeps its own copy of both registers and both tables. Every accepted
  // transfer on the input side pushes one predicted double pattern, and every strobed
  // result is compared with the oldest one.
  class exp_scoreboard;
    logic [63:0] scale_reg;
    logic [63:0] limit_reg;
    logic [63:0] fine_tab[256];
    logic [63:0] coarse_tab[256];
    logic [63:0] pending_q[$];
    int unsigned errors;

    function new();
      scale_reg = '0;
      limit_reg = '0;
      errors    = 0;
      for (int k = 0; k < 256; k++) begin
        fine_tab[k]   = pow2_pattern(k, 16);
        coarse_tab[k] = pow2_pattern(k, 8);
      end
    endfunction

    // Correctly rounded 2^(k / 2^sh) from the series of exp(k ln2 / 2^sh) in Q128.
    function logic [63:0] pow2_pattern(int k, int sh);
      logic [159:0] arg;
      logic [159:0] acc;
      logic [159:0] term;
      logic [319:0] wide;
      logic         round_up;
      arg  = ({32'd0, LN2_Q128} * k) >> sh;
      acc  = 160'd1 << 128;
      term = acc;
      for (int n = 1; n <= 40; n++) begin
        wide = {160'd0, term} * {160'd0, arg};
        term = wide[287:128] / n;
        acc  = acc + term;
      end
      round_up = acc[75] && ((|acc[74:0]) || acc[76]);
      return teau_pkg::ONE_BITS + {12'd0, acc[127:76]} + {63'd0, round_up};
    endfunction

    function logic [63:0] exp_of(logic [63:0] xb);
      real         xr;
      real         prod;
      real         r;
      logic [31:0] n;
      logic [63:0] w;
      xr = $bitstoreal(xb);
      if (xb == '0) return teau_pkg::ONE_BITS;
      if (xb <= limit_reg) begin
        prod = xr * $bitstoreal(scale_reg);
        if (prod != prod) n = 32'd0;
        else if (prod >= 2147483648.0) n = 32'h7FFF_FFFF;
        else if (!(prod > -2147483649.0)) n = 32'h8000_0000;
        else n = $rtoi(prod);
        w = coarse_tab[n[15:8]] + {n[27:16], 52'd0};
        r = $bitstoreal(fine_tab[n[7:0]]) * $bitstoreal(w);
        return (r != r) ? teau_pkg::CANON_NAN : $realtobits(r);
      end
      return (xr <= 0.0) ? teau_pkg::ZERO_BITS : teau_pkg::CANON_NAN;
    endfunction

    function void note_input(logic [63:0] xb);
      pending_q.push_back(exp_of(xb));
    endfunction

    function void check_result(logic [63:0] act);
      logic [63:0] exp_bits;
      if (pending_q.size() == 0) begin
        $error("result_bits: no result expected, actual %h", act);
        errors++;
        return;
      end
      exp_bits = pending_q.pop_front();
      if (act !== exp_bits) begin
        $error("result_bits: expected %h, actual %h", exp_bits, act);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] x_bits_i;
  logic        result_valid_o;
  logic [63:0] result_bits_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  exp_scoreboard sb;
  int unsigned   cycle_cnt;
  int unsigned   burst_left;

  table_exp_approximation_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .x_bits_i       (x_bits_i),
    .result_valid_o (result_valid_o),
    .result_bits_o  (result_bits_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A hung pipeline must not keep the run alive for ever.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results are sampled in the active region of the edge that ends their cycle, so the
  // values seen are the ones the block showed during that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_bits_o);
  end

  // One APB write: a setup cycle, then an access cycle that completes once pready is
  // seen high. The scoreboard copy is updated at the completing edge, and the bus then
  // goes idle before the task returns.
  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == teau_pkg::ADDR_SCALE) sb.scale_reg = data;
    else if (addr == teau_pkg::ADDR_LIMIT) sb.limit_reg = data;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one item and waits for its transfer. Within a burst start_i stays high from
  // one item to the next; between bursts it may drop for a random gap.
  task automatic send_x(input logic [63:0] xb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i  <= 1'b1;
    x_bits_i <= xb;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(xb);
  endtask

  // Waits until every predicted result has come back, then lets the pipeline settle.
  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] real_in(real span);
    return $realtobits((($urandom() / 4294967296.0) - 0.5) * 2.0 * span);
  endfunction

  // Random arguments: mostly moderate reals that land on the table path, with raw
  // patterns, specials, random exponents and values around the configured limit.
  function automatic logic [63:0] random_x();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = real_in(2.0);
      2, 3:    v = real_in(200.0);
      4:       v = real_in(40000.0);
      5:       v = real_in(1.0e-4);
      6:       v = {$urandom(), $urandom()};
      7: begin
        case ($urandom_range(0, 5))
          0:       v = 64'h7FF0_0000_0000_0000;
          1:       v = 64'hFFF0_0000_0000_0000;
          2:       v = {1'b0, 11'h7FF, 20'h0, $urandom()} | 64'h1;
          3:       v = 64'h8000_0000_0000_0000;
          4:       v = {32'h0, $urandom()};
          default: v = '0;
        endcase
      end
      8:       v = {1'($urandom()), 11'($urandom()), 20'($urandom()), $urandom()};
      default: v = sb.limit_reg + 64'($signed(8'($urandom())));
    endcase
    return v;
  endfunction

  logic [63:0] scale_set[6];
  logic [63:0] limit_set[6];
  logic [63:0] corner_x[$];

  initial begin
    sb         = new();
    cycle_cnt  = 0;
    burst_left = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    x_bits_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // Register settings per phase, extremes of both included.
    scale_set = '{64'h0, $realtobits(94548.46224), $realtobits(65536.0),
                  {$urandom(), $urandom()}, 64'hFFFF_FFFF_FFFF_FFFF,
                  $realtobits(-217706.0)};
    limit_set = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, $realtobits(10.0),
                  {$urandom(), $urandom()}, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF};

    // Zero, negative zero, all ones, smallest subnormal, infinities, NaNs, largest finite,
    // unit values and arguments big enough to saturate the integer in both directions.
    corner_x = '{64'h0, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                 $realtobits(1.0), $realtobits(-1.0), $realtobits(0.5),
                 $realtobits(1.0e6), $realtobits(-1.0e6), $realtobits(22713.0),
                 $realtobits(-22713.0), $realtobits(1.0e-300)};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      reg_write(teau_pkg::ADDR_SCALE, scale_set[ph]);
      reg_write(teau_pkg::ADDR_LIMIT, limit_set[ph]);
      foreach (corner_x[k]) send_x(corner_x[k]);
      send_x(limit_set[ph]);
      send_x(limit_set[ph] + 64'd1);
      for (int k = 0; k < 172; k++) send_x(random_x());
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: table_exp_approximation_unit.f
src/teau_pkg.sv
src/teau_fmul.sv
src/table_exp_approximation_unit.sv
sim/table_exp_approximation_unit_tb.sv
